@@ rtl/nfa_lme_pkg.sv @@
// ----------------------------------------------------------------------------
// nfa_lme_pkg
// shared types and constants of the nfa longest match engine
// ----------------------------------------------------------------------------
`default_nettype none
package nfa_lme_pkg;
  localparam int NODES_DEFAULT       = 64;
  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int IDX_W   = 6;
  localparam int LABEL_W = 8;
  localparam int OUT_LEN_W = 16;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_ACCEPT = 2'd1;
  localparam logic [1:0] REG_EPS    = 2'd2;
  localparam logic [1:0] REG_TERM   = 2'd3;

  typedef struct packed {
    logic [LABEL_W-1:0] lab1;
    logic [LABEL_W-1:0] lab2;
    logic [IDX_W-1:0]   tgt1;
    logic [IDX_W-1:0]   tgt2;
    logic               e1;
    logic               e2;
  } node_t;
endpackage
`default_nettype wire

@@ rtl/nfa_longest_match_engine.sv @@
// ----------------------------------------------------------------------------
// nfa_longest_match_engine
// thompson nfa simulation with longest match tracking
// ----------------------------------------------------------------------------
// One item at a time. A node write goes through the write state. A character
// walks the node memory once for the transition and then repeats closure
// sweeps over every entry until a sweep adds no node; the sweeps that still
// add a node are at most the depth of the longest new epsilon chain. A begin
// item runs only the closure sweeps. The node memory has a single read port,
// read one entry a cycle. A terminator or end item is taken in idle and its
// result is offered from the next cycle in an output register; only a further
// terminator or end item waits while that result is still held off, and it is
// taken in the cycle the held result is transferred.
`default_nettype none
module nfa_longest_match_engine #(
  parameter int NODES       = nfa_lme_pkg::NODES_DEFAULT,
  parameter int LENGTH_BITS = nfa_lme_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  node_index,
  input  wire logic [7:0]  label_one,
  input  wire logic [7:0]  label_two,
  input  wire logic [5:0]  target_one,
  input  wire logic [5:0]  target_two,
  input  wire logic        has_one,
  input  wire logic        has_two,
  input  wire logic [7:0]  symbol,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             matched,
  output logic [15:0]      match_length,
  output logic             by_terminator
);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRANS = 3'd1;
  localparam logic [2:0] ST_CLOSE = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [5:0] start_node, accept_node;
  logic [7:0] epsilon_label, terminator_char;

  nfa_lme_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_node, .accept_node, .epsilon_label, .terminator_char
  );

  // node memory, one read port walked by the sweep counter
  nfa_lme_pkg::node_t node_mem [NODES];
  nfa_lme_pkg::node_t rd_node;

  logic [2:0]  state;
  logic [CW-1:0] ptr;          // read address of the sweep
  logic          rd_ok;        // rd_node holds entry rd_idx
  logic [AW-1:0] rd_idx;
  logic [NODES-1:0] active_set, next_set;
  logic          changed;
  logic          cnt_inc_en;   // character pass, count it at the end
  logic [7:0]    sym;
  logic [LENGTH_BITS-1:0] consumed_count, best_length;
  logic          best_valid, word_done;
  nfa_lme_pkg::node_t wr_node;
  logic [5:0]    wr_idx;

  // node indexes sized to the memory
  logic [AW-1:0] start_a, accept_a, wr_a, tgt1_a, tgt2_a;
  assign start_a  = AW'(start_node);
  assign accept_a = AW'(accept_node);
  assign wr_a     = AW'(wr_idx);
  assign tgt1_a   = AW'(rd_node.tgt1);
  assign tgt2_a   = AW'(rd_node.tgt2);

  logic accept_in, accept_out, emit_req, emit_now;
  // item that closes the open word and needs the output register
  assign emit_req   = !word_done && (cmd == nfa_lme_pkg::CMD_END ||
                      (cmd == nfa_lme_pkg::CMD_CHAR && symbol == terminator_char));
  assign accept_in  = in_valid && !in_stall;
  assign accept_out = out_valid && !out_stall;
  assign in_stall   = (state != ST_IDLE) || (emit_req && out_valid && out_stall);
  assign emit_now   = accept_in && emit_req;

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && 32'(wr_idx) < NODES)
      node_mem[wr_a] <= wr_node;
    rd_node <= node_mem[ptr[AW-1:0]];
  end

  // per cycle: one node is examined by the shared edge unit
  logic src_on, hit1, hit2, grew;
  logic [7:0] want;
  logic [NODES-1:0] upd;
  always_comb begin
    src_on = (state == ST_TRANS) ? active_set[rd_idx] : next_set[rd_idx];
    want   = (state == ST_TRANS) ? sym : epsilon_label;
    hit1 = rd_ok && src_on && rd_node.e1 && rd_node.lab1 == want
           && 32'(rd_node.tgt1) < NODES;
    hit2 = rd_ok && src_on && rd_node.e2 && rd_node.lab2 == want
           && 32'(rd_node.tgt2) < NODES;
    upd = '0;
    if (hit1) upd[tgt1_a] = 1'b1;
    if (hit2) upd[tgt2_a] = 1'b1;
    grew = (upd & ~next_set) != '0;
  end

  // seed of the closure at begin
  logic [NODES-1:0] start_set;
  always_comb begin
    start_set = '0;
    if (32'(start_node) < NODES) start_set[start_a] = 1'b1;
  end

  logic [LENGTH_BITS-1:0] cnt_inc;
  assign cnt_inc = (consumed_count < LEN_MAX) ? consumed_count + 1'b1 : consumed_count;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      matched <= best_valid;
      match_length <= best_valid ?
        ((32'(best_length) > 32'hFFFF) ? 16'hFFFF : 16'(best_length)) : 16'd0;
      by_terminator <= (cmd == nfa_lme_pkg::CMD_CHAR);
      out_valid <= 1'b1;
    end else if (accept_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; word_done <= 1'b1;
      active_set <= '0; consumed_count <= '0; best_length <= '0;
      best_valid <= 1'b0; ptr <= '0; rd_ok <= 1'b0; changed <= 1'b0;
      cnt_inc_en <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            unique case (cmd)
              nfa_lme_pkg::CMD_WRITE: begin
                wr_idx <= node_index;
                wr_node <= '{label_one, label_two, target_one, target_two,
                             has_one, has_two};
                state <= ST_WRITE;
              end
              nfa_lme_pkg::CMD_BEGIN: begin
                next_set <= start_set;
                consumed_count <= '0; best_length <= '0; best_valid <= 1'b0;
                word_done <= 1'b0; cnt_inc_en <= 1'b0;
                ptr <= '0; rd_ok <= 1'b0; changed <= 1'b0;
                state <= ST_CLOSE;
              end
              default: begin
                if (emit_req) begin
                  word_done <= 1'b1;
                end else if (!word_done) begin
                  sym <= symbol; next_set <= '0; cnt_inc_en <= 1'b1;
                  ptr <= '0; rd_ok <= 1'b0;
                  state <= ST_TRANS;
                end
              end
            endcase
          end
        end
        ST_WRITE: state <= ST_IDLE;
        ST_TRANS, ST_CLOSE: begin
          next_set <= next_set | upd;
          rd_idx <= ptr[AW-1:0];
          if (32'(ptr) == NODES) begin
            // last entry consumed this cycle
            rd_ok <= 1'b0; ptr <= '0;
            if (state == ST_TRANS) begin
              changed <= 1'b0; state <= ST_CLOSE;
            end else if (changed || grew) begin
              changed <= 1'b0;
            end else begin
              state <= ST_FINAL;
            end
          end else begin
            if (state == ST_CLOSE && grew) changed <= 1'b1;
            rd_ok <= 1'b1; ptr <= ptr + 1'b1;
          end
        end
        ST_FINAL: begin
          active_set <= next_set;
          if (cnt_inc_en) begin
            consumed_count <= cnt_inc;
            if (32'(accept_node) < NODES && next_set[accept_a]) begin
              best_length <= cnt_inc; best_valid <= 1'b1;
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/nfa_lme_regs.sv @@
// ----------------------------------------------------------------------------
// nfa_lme_regs
// apb configuration registers
// ----------------------------------------------------------------------------
`default_nettype none
module nfa_lme_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [nfa_lme_pkg::IDX_W-1:0]   start_node,
  output logic [nfa_lme_pkg::IDX_W-1:0]   accept_node,
  output logic [nfa_lme_pkg::LABEL_W-1:0] epsilon_label,
  output logic [nfa_lme_pkg::LABEL_W-1:0] terminator_char
);
  logic [1:0] reg_sel;
  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_node      <= 6'd0;
      accept_node     <= 6'd1;
      epsilon_label   <= 8'd95;
      terminator_char <= 8'd32;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        nfa_lme_pkg::REG_START:  start_node      <= pwdata[5:0];
        nfa_lme_pkg::REG_ACCEPT: accept_node     <= pwdata[5:0];
        nfa_lme_pkg::REG_EPS:    epsilon_label   <= pwdata[7:0];
        nfa_lme_pkg::REG_TERM:   terminator_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      nfa_lme_pkg::REG_START:  prdata = {26'd0, start_node};
      nfa_lme_pkg::REG_ACCEPT: prdata = {26'd0, accept_node};
      nfa_lme_pkg::REG_EPS:    prdata = {24'd0, epsilon_label};
      nfa_lme_pkg::REG_TERM:   prdata = {24'd0, terminator_char};
      default:                 prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nfa longest match engine
// ----------------------------------------------------------------------------
// The node table is loaded in full at the start of each phase, and then the
// engine is driven with directed words and with random words over a small
// alphabet. A behavioural copy of the engine, updated at each accepted
// transfer, predicts every word result. The monitor checks each result
// against the oldest prediction. Between phases the configuration registers
// are rewritten while the engine is idle.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] node_index;
    logic [7:0] label_one;
    logic [7:0] label_two;
    logic [5:0] target_one;
    logic [5:0] target_two;
    logic       has_one;
    logic       has_two;
    logic [7:0] symbol;
  } nfa_item_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] match_length;
    logic        by_terminator;
  } word_result_t;

  // long enough for a character item to finish in the worst case
  localparam int SETTLE_CYCLES = 4500;
  localparam int LONG_HOLD     = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [1:0]  cmd = '0;
  logic [5:0]  node_index = '0;
  logic [7:0]  label_one = '0, label_two = '0;
  logic [5:0]  target_one = '0, target_two = '0;
  logic        has_one = 1'b0, has_two = 1'b0;
  logic [7:0]  symbol = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire         matched;
  wire  [15:0] match_length;
  wire         by_terminator;

  always #10 clk = ~clk;

  nfa_longest_match_engine dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .node_index(node_index),
    .label_one(label_one), .label_two(label_two), .target_one(target_one),
    .target_two(target_two), .has_one(has_one), .has_two(has_two), .symbol(symbol),
    .out_valid(out_valid), .out_stall(out_stall), .matched(matched),
    .match_length(match_length), .by_terminator(by_terminator)
  );

  // ---------------------------------------------------------------------------
  // behavioural copy of the engine
  // ---------------------------------------------------------------------------
  nfa_lme_pkg::node_t graph [64];
  logic [63:0]  live_nodes = '0;
  logic [15:0]  chars_taken = '0;
  logic [15:0]  longest_hit = '0;
  logic         hit_seen = 1'b0;
  logic         word_open = 1'b0;
  logic [5:0]   cfg_start = 6'd0;
  logic [5:0]   cfg_accept = 6'd1;
  logic [7:0]   cfg_eps = 8'd95;
  logic [7:0]   cfg_term = 8'd32;

  nfa_item_t    pending_items [$];
  word_result_t expected_words [$];
  int           error_count = 0;

  // grow a node set over empty moves until it stops changing
  function automatic logic [63:0] eps_closure(logic [63:0] s);
    logic [63:0] prev;
    do begin
      prev = s;
      for (int i = 0; i < 64; i++) begin
        if (s[i]) begin
          if (graph[i].e1 && graph[i].lab1 == cfg_eps) s[graph[i].tgt1] = 1'b1;
          if (graph[i].e2 && graph[i].lab2 == cfg_eps) s[graph[i].tgt2] = 1'b1;
        end
      end
    end while (s != prev);
    return s;
  endfunction

  task automatic finish_word(logic by_term);
    word_result_t r;
    r.matched       = hit_seen;
    r.match_length  = hit_seen ? longest_hit : 16'd0;
    r.by_terminator = by_term;
    expected_words.push_back(r);
    word_open = 1'b0;
  endtask

  task automatic predict_item(nfa_item_t it);
    logic [63:0] nxt;
    case (it.cmd)
      nfa_lme_pkg::CMD_WRITE: begin
        graph[it.node_index] = '{lab1: it.label_one, lab2: it.label_two,
                                 tgt1: it.target_one, tgt2: it.target_two,
                                 e1: it.has_one, e2: it.has_two};
      end
      nfa_lme_pkg::CMD_BEGIN: begin
        nxt = '0;
        nxt[cfg_start] = 1'b1;
        live_nodes  = eps_closure(nxt);
        chars_taken = '0;
        longest_hit = '0;
        hit_seen    = 1'b0;
        word_open   = 1'b1;
      end
      nfa_lme_pkg::CMD_END: begin
        if (word_open) finish_word(1'b0);
      end
      default: begin
        if (!word_open) begin
          // idle: nothing happens
        end else if (it.symbol == cfg_term) begin
          finish_word(1'b1);
        end else begin
          nxt = '0;
          for (int i = 0; i < 64; i++) begin
            if (live_nodes[i]) begin
              if (graph[i].e1 && graph[i].lab1 == it.symbol) nxt[graph[i].tgt1] = 1'b1;
              if (graph[i].e2 && graph[i].lab2 == it.symbol) nxt[graph[i].tgt2] = 1'b1;
            end
          end
          live_nodes = eps_closure(nxt);
          if (chars_taken != 16'hFFFF) chars_taken++;
          if (live_nodes[cfg_accept]) begin
            longest_hit = chars_taken;
            hit_seen    = 1'b1;
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers pending items with random gaps
  // ---------------------------------------------------------------------------
  nfa_item_t on_offer;
  int        gap_left = 0;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    logic held;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // transfer completes at this edge
      if (in_valid && !in_stall) predict_item(on_offer);
      held = in_valid && in_stall;
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_offer   = pending_items.pop_front();
          cmd        <= on_offer.cmd;
          node_index <= on_offer.node_index;
          label_one  <= on_offer.label_one;
          label_two  <= on_offer.label_two;
          target_one <= on_offer.target_one;
          target_two <= on_offer.target_two;
          has_one    <= on_offer.has_one;
          has_two    <= on_offer.has_two;
          symbol     <= on_offer.symbol;
          in_valid   <= 1'b1;
          gap_left   = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: random stalls, one long hold-off, checks every transfer
  // ---------------------------------------------------------------------------
  int words_seen = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    word_result_t got, want;
    int r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{matched, match_length, by_terminator};
        words_seen++;
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result m=%0b len=%0d term=%0b",
                     $realtime, got.matched, got.match_length, got.by_terminator);
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: result %0d expected m=%0b len=%0d term=%0b, got m=%0b len=%0d term=%0b",
                       $realtime, words_seen, want.matched, want.match_length,
                       want.by_terminator, got.matched, got.match_length, got.by_terminator);
          end
        end
      end
      // one long hold-off so the engine backs up and stalls its input
      if (!long_hold_done && words_seen == 30) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) out_stall <= 1'b0;
        else if (r < 95) out_stall <= 1'b1;
        else begin
          hold_left = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic nfa_item_t noise_item(logic [1:0] c);
    nfa_item_t it;
    it = nfa_item_t'(46'({$urandom, $urandom}));
    it.cmd = c;
    return it;
  endfunction

  function automatic logic [7:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return cfg_eps;
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 87) return cfg_eps;
    if (r < 90) return cfg_term;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_node(int idx, logic [7:0] l1, logic [7:0] l2,
                           int t1, int t2, logic h1, logic h2);
    nfa_item_t it;
    it = noise_item(nfa_lme_pkg::CMD_WRITE);
    it.node_index = 6'(idx);
    it.label_one = l1;
    it.label_two = l2;
    it.target_one = 6'(t1);
    it.target_two = 6'(t2);
    it.has_one = h1;
    it.has_two = h2;
    pending_items.push_back(it);
  endtask

  task automatic push_random_node(int idx);
    push_node(idx, pick_label(), pick_label(), $urandom_range(0, 63),
              $urandom_range(0, 63), $urandom_range(0, 99) < 80,
              $urandom_range(0, 99) < 50);
  endtask

  task automatic push_char(logic [7:0] s);
    nfa_item_t it;
    it = noise_item(nfa_lme_pkg::CMD_CHAR);
    it.symbol = s;
    pending_items.push_back(it);
  endtask

  task automatic push_cmd(logic [1:0] c);
    pending_items.push_back(noise_item(c));
  endtask

  // well-formed words with random content, plus some broken ones and noise
  task automatic push_random_words(int count);
    int n, r, added;
    added = 0;
    while (added < count) begin
      push_cmd(nfa_lme_pkg::CMD_BEGIN);
      n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 3) push_random_node($urandom_range(0, 63));
        push_char(pick_symbol());
      end
      r = $urandom_range(0, 99);
      if (r < 45) push_char(cfg_term);
      else if (r < 85) push_cmd(nfa_lme_pkg::CMD_END);
      // otherwise the word is left open, closed by a following end or dropped by the next begin
      added += n + 2;
      if ($urandom_range(0, 99) < 10) begin
        push_cmd(nfa_lme_pkg::CMD_END);
        push_char(pick_symbol());
      end
    end
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      nfa_lme_pkg::REG_START:  cfg_start  = v[5:0];
      nfa_lme_pkg::REG_ACCEPT: cfg_accept = v[5:0];
      nfa_lme_pkg::REG_EPS:    cfg_eps    = v[7:0];
      default:                 cfg_term   = v[7:0];
    endcase
  endtask

  // sender pauses until every result is in, then lets the engine settle
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(int s, int a, int e, int t);
    reg_write(nfa_lme_pkg::REG_START,  {26'($urandom), 6'(s)});
    reg_write(nfa_lme_pkg::REG_ACCEPT, {26'($urandom), 6'(a)});
    reg_write(nfa_lme_pkg::REG_EPS,    {24'($urandom), 8'(e)});
    reg_write(nfa_lme_pkg::REG_TERM,   {24'($urandom), 8'(t)});
    // full table load so no entry is ever read unwritten
    for (int i = 0; i < 64; i++) push_random_node(i);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    start_phase(0, 1, 95, 32);
    // small hand-built automaton on nodes 0..3
    push_node(0, "a", cfg_eps, 1, 2, 1'b1, 1'b1);
    push_node(1, "b", 8'h00, 1, 0, 1'b1, 1'b0);
    push_node(2, "c", 8'h00, 3, 0, 1'b1, 1'b0);
    push_node(3, cfg_eps, cfg_eps, 1, 1, 1'b1, 1'b0);
    push_char("a");                 // idle character ignored
    push_cmd(nfa_lme_pkg::CMD_END); // idle end ignored
    push_cmd(nfa_lme_pkg::CMD_BEGIN);
    push_char("a");
    push_char("b");
    push_char("x");                 // set dies, best kept
    push_char(cfg_term);
    push_cmd(nfa_lme_pkg::CMD_BEGIN);
    push_cmd(nfa_lme_pkg::CMD_BEGIN); // open word dropped without result
    push_char("c");
    push_char(cfg_eps);             // character equal to the empty-move label
    push_cmd(nfa_lme_pkg::CMD_END);
    push_cmd(nfa_lme_pkg::CMD_BEGIN);
    push_cmd(nfa_lme_pkg::CMD_END); // empty word never matches
    push_cmd(nfa_lme_pkg::CMD_BEGIN);
    push_char("a");
    push_node(63, 8'hFF, 8'h00, 63, 0, 1'b1, 1'b1);  // write during a word
    push_char(8'h00);
    push_char(8'hFF);
    push_char(cfg_term);
    push_random_words(230);
    drain();

    start_phase(63, 0, 0, 255);
    push_random_words(250);
    drain();

    // start equals accept
    start_phase(5, 5, 255, 0);
    push_random_words(250);
    drain();

    // empty-move label equal to the terminator
    start_phase(0, 63, 255, 255);
    push_random_words(250);
    drain();

    if (error_count == 0) begin
      $display("nfa_longest_match_engine verification clean");
    end else begin
      $display("nfa_longest_match_engine verification failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("nfa_longest_match_engine verification failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/nfa_lme_pkg.sv
rtl/nfa_lme_regs.sv
rtl/nfa_longest_match_engine.sv
bench/tb_top.sv
